// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the damped spring force RTL.
// Depends on nothing; the bodies drop out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, prop)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- hdl/dsf_pkg.sv -----
// Package of the damped spring force block: widths, register codes and
// the records that travel between the front end, the queue and the back end.
`timescale 1ns / 1ps
package dsf_pkg;
   localparam int unsigned COORD_W     = 32;
   localparam int unsigned DIFF_W      = 33;
   localparam int unsigned PROD_W      = 66;
   localparam int unsigned SUM_W       = 66;
   localparam int unsigned VD_W        = 67;
   localparam int unsigned ROOT_W      = 33;
   localparam int unsigned K_W         = 32;
   localparam int unsigned TERM_W      = 62;
   localparam int unsigned NUM1_W      = 65;
   localparam int unsigned PART_W      = 63;
   localparam int unsigned NUM2_W      = 94;
   localparam int unsigned DEN2_W      = 39;
   localparam int unsigned SMAG_W      = 63;
   localparam int unsigned PA_W        = 65;
   localparam int unsigned PB_W        = 64;
   localparam int unsigned NUM3_W      = 96;
   localparam int unsigned FORCE_QW    = 32;
   localparam int unsigned CSR_ADDR_W  = 3;
   localparam int unsigned CSR_DATA_W  = 32;
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam logic [DEN2_W-1:0] DAMP_DIV = 39'd100;
   localparam logic [CSR_DATA_W-1:0] STIFFNESS_RESET   = 32'h0001_0000;
   localparam logic [CSR_DATA_W-1:0] REST_LENGTH_RESET = 32'h0001_0000;
   localparam logic REG_STIFFNESS   = 1'b0;
   localparam logic REG_REST_LENGTH = 1'b1;

   typedef struct packed {
      logic [K_W-1:0] stiffness;
      logic [K_W-1:0] rest_len;
   } cfg_type;

   typedef struct packed {
      logic [2:0][DIFF_W-1:0] d;
      logic [SUM_W-1:0]       sum_sq;
      logic                   vd_neg;
      logic [SUM_W-1:0]       vd_mag;
      logic                   zero;
   } entry_type;

   typedef struct packed {
      logic [2:0][DIFF_W-1:0] d;
      logic                   vd_neg;
      logic [SUM_W-1:0]       vd_mag;
      logic                   zero;
   } sq_tag_type;

   typedef struct packed {
      logic [2:0][DIFF_W-1:0] d;
      logic                   vd_neg;
      logic [ROOT_W-1:0]      root;
      logic                   zero;
   } divb_tag_type;

   typedef struct packed {
      logic [TERM_W-1:0]      m1;
      logic                   diff_neg;
      logic                   vd_neg;
      logic [2:0][DIFF_W-1:0] d;
      logic [ROOT_W-1:0]      root;
      logic                   zero;
   } divc_tag_type;
endpackage

// ----- hdl/dsf_channels.sv -----
// Request and response channel interfaces of the damped spring force block.
// Depends on nothing.
`timescale 1ns / 1ps
interface dsf_req_if;
   logic valid;
   logic ready;
   logic signed [31:0] node_a_pos_x, node_a_pos_y, node_a_pos_z;
   logic signed [31:0] node_b_pos_x, node_b_pos_y, node_b_pos_z;
   logic signed [31:0] node_a_vel_x, node_a_vel_y, node_a_vel_z;
   logic signed [31:0] node_b_vel_x, node_b_vel_y, node_b_vel_z;
   modport source (output valid, node_a_pos_x, node_a_pos_y, node_a_pos_z,
      node_b_pos_x, node_b_pos_y, node_b_pos_z, node_a_vel_x, node_a_vel_y,
      node_a_vel_z, node_b_vel_x, node_b_vel_y, node_b_vel_z, input ready);
   modport sink (input valid, node_a_pos_x, node_a_pos_y, node_a_pos_z,
      node_b_pos_x, node_b_pos_y, node_b_pos_z, node_a_vel_x, node_a_vel_y,
      node_a_vel_z, node_b_vel_x, node_b_vel_y, node_b_vel_z, output ready);
endinterface

interface dsf_rsp_if;
   logic valid;
   logic ready;
   logic signed [31:0] force_x, force_y, force_z;
   logic zero_length;
   modport source (output valid, force_x, force_y, force_z, zero_length, input ready);
   modport sink (input valid, force_x, force_y, force_z, zero_length, output ready);
endinterface

// ----- hdl/dsf_front.sv -----
// Front end: accepts requests, forms separation, relative velocity and their
// squares and products. Depends on dsf_pkg and dsf_req_if.
`timescale 1ns / 1ps
module dsf_front (
   input  logic               clock,
   input  logic               reset,
   dsf_req_if.sink            req_if,
   output logic               push_valid,
   input  logic               push_ready,
   output dsf_pkg::entry_type push_entry
);
   import dsf_pkg::*;

   logic s1_valid_ff, s1_valid_in, s1_ready;
   logic s2_valid_ff, s2_valid_in, s2_ready;
   logic signed [DIFF_W-1:0] d_ff [3];
   logic signed [DIFF_W-1:0] v_ff [3];
   logic signed [DIFF_W-1:0] d_in [3];
   logic signed [DIFF_W-1:0] v_in [3];
   logic signed [DIFF_W-1:0] d2_ff [3];
   logic signed [PROD_W-1:0] sq_ff [3];
   logic signed [PROD_W-1:0] vd_ff [3];
   logic signed [VD_W-1:0]   vd_sum;
   logic [VD_W-1:0]          vd_abs;

   assign s2_ready     = !s2_valid_ff || push_ready;
   assign s1_ready     = !s1_valid_ff || s2_ready;
   assign req_if.ready = s1_ready;
   assign s1_valid_in  = req_if.valid ? 1'b1 : (s2_ready ? 1'b0 : s1_valid_ff);
   assign s2_valid_in  = s1_valid_ff ? 1'b1 : (push_ready ? 1'b0 : s2_valid_ff);

   always_comb begin
      d_in[0] = $signed({req_if.node_b_pos_x[31], req_if.node_b_pos_x})
              - $signed({req_if.node_a_pos_x[31], req_if.node_a_pos_x});
      d_in[1] = $signed({req_if.node_b_pos_y[31], req_if.node_b_pos_y})
              - $signed({req_if.node_a_pos_y[31], req_if.node_a_pos_y});
      d_in[2] = $signed({req_if.node_b_pos_z[31], req_if.node_b_pos_z})
              - $signed({req_if.node_a_pos_z[31], req_if.node_a_pos_z});
      v_in[0] = $signed({req_if.node_b_vel_x[31], req_if.node_b_vel_x})
              - $signed({req_if.node_a_vel_x[31], req_if.node_a_vel_x});
      v_in[1] = $signed({req_if.node_b_vel_y[31], req_if.node_b_vel_y})
              - $signed({req_if.node_a_vel_y[31], req_if.node_a_vel_y});
      v_in[2] = $signed({req_if.node_b_vel_z[31], req_if.node_b_vel_z})
              - $signed({req_if.node_a_vel_z[31], req_if.node_a_vel_z});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= s1_valid_in;
         end
         if (s2_ready) begin
            s2_valid_ff <= s2_valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && req_if.valid) begin
         for (int i = 0; i < 3; i++) begin
            d_ff[i] <= d_in[i];
            v_ff[i] <= v_in[i];
         end
      end
      if (s2_ready && s1_valid_ff) begin
         for (int i = 0; i < 3; i++) begin
            d2_ff[i] <= d_ff[i];
            sq_ff[i] <= PROD_W'(d_ff[i]) * PROD_W'(d_ff[i]);
            vd_ff[i] <= PROD_W'(v_ff[i]) * PROD_W'(d_ff[i]);
         end
      end
   end

   always_comb begin
      vd_sum = $signed({vd_ff[0][PROD_W-1], vd_ff[0]})
             + $signed({vd_ff[1][PROD_W-1], vd_ff[1]})
             + $signed({vd_ff[2][PROD_W-1], vd_ff[2]});
      vd_abs = vd_sum[VD_W-1] ? VD_W'(-vd_sum) : VD_W'(vd_sum);
      for (int i = 0; i < 3; i++) begin
         push_entry.d[i] = d2_ff[i];
      end
      push_entry.sum_sq = SUM_W'(sq_ff[0][PROD_W-2:0]) + SUM_W'(sq_ff[1][PROD_W-2:0])
                        + SUM_W'(sq_ff[2][PROD_W-2:0]);
      push_entry.vd_neg = vd_sum[VD_W-1];
      push_entry.vd_mag = vd_abs[SUM_W-1:0];
      push_entry.zero   = (push_entry.sum_sq == '0);
   end

   assign push_valid = s2_valid_ff;
endmodule

// ----- hdl/dsf_fifo.sv -----
// Short queue between the front end and the back end.
// Depends on dsf_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dsf_fifo #(
   parameter int unsigned DEPTH = dsf_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  dsf_pkg::entry_type in_entry,
   output logic               out_valid,
   input  logic               pop,
   output dsf_pkg::entry_type out_entry
);
   import dsf_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   entry_type        slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, take;

   assign in_ready  = (count_ff < CNT_W'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign push      = in_valid && in_ready;
   assign take      = pop && out_valid;
   assign out_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (take) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !take) begin
         count_in = count_ff + 1'b1;
      end else if (take && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_entry;
      end
   end

   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CNT_W'(DEPTH))
   `ASSERT_NEXT(a_push_grows, clock, reset, push && !take, count_ff == $past(count_ff) + 1'b1)
   `ASSERT_NEXT(a_take_shrinks, clock, reset, take && !push, count_ff == $past(count_ff) - 1'b1)
endmodule

// ----- hdl/dsf_sqrt.sv -----
// Pipelined integer square root, one root bit per stage.
// Depends on nothing beyond its parameters.
`timescale 1ns / 1ps
module dsf_sqrt #(
   parameter int unsigned RAD_W  = 66,
   parameter int unsigned ROOT_W = 33,
   parameter int unsigned TAG_W  = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [RAD_W-1:0]  in_rad,
   input  logic [TAG_W-1:0]  in_tag,
   output logic              out_valid,
   output logic [ROOT_W-1:0] out_root,
   output logic [TAG_W-1:0]  out_tag
);
   localparam int unsigned T_W = ((RAD_W > 2 * ROOT_W) ? RAD_W : 2 * ROOT_W) + 1;

   logic [ROOT_W:0]   valid_ff;
   logic [RAD_W-1:0]  rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W+1];
   logic [TAG_W-1:0]  tag_ff  [ROOT_W+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[ROOT_W-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= in_rad;
         root_ff[0] <= '0;
         tag_ff[0]  <= in_tag;
      end
   end

   for (genvar j = 1; j <= ROOT_W; j++) begin : g_stage
      localparam int unsigned SH = ROOT_W - j;
      logic [T_W-1:0] trial;
      logic           hit;
      assign trial = (T_W'(root_ff[j-1]) << (SH + 1)) + (T_W'(1) << (2 * SH));
      assign hit   = (T_W'(rem_ff[j-1]) >= trial);
      always_ff @(posedge clock) begin
         if (en) begin
            root_ff[j] <= hit ? (root_ff[j-1] | (ROOT_W'(1) << SH)) : root_ff[j-1];
            tag_ff[j]  <= tag_ff[j-1];
         end
      end
      if (j < ROOT_W) begin : g_rem
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[j] <= hit ? (rem_ff[j-1] - trial[RAD_W-1:0]) : rem_ff[j-1];
            end
         end
      end
   end

   assign out_valid = valid_ff[ROOT_W];
   assign out_root  = root_ff[ROOT_W];
   assign out_tag   = tag_ff[ROOT_W];
endmodule

// ----- hdl/dsf_div.sv -----
// Pipelined saturating unsigned divider, one quotient bit per stage.
// Depends on nothing beyond its parameters.
`timescale 1ns / 1ps
module dsf_div #(
   parameter int unsigned NUM_W = 65,
   parameter int unsigned DEN_W = 32,
   parameter int unsigned QUO_W = 62,
   parameter int unsigned TAG_W = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [NUM_W-1:0] in_num,
   input  logic [DEN_W-1:0] in_den,
   input  logic [TAG_W-1:0] in_tag,
   output logic             out_valid,
   output logic [QUO_W-1:0] out_quo,
   output logic [TAG_W-1:0] out_tag
);
   localparam int unsigned EXT_W = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

   logic [QUO_W:0]   valid_ff;
   logic [EXT_W-1:0] rem_ff [QUO_W];
   logic [EXT_W-1:0] den_ff [QUO_W];
   logic [QUO_W-1:0] quo_ff [QUO_W+1];
   logic             sat_ff [QUO_W+1];
   logic [TAG_W-1:0] tag_ff [QUO_W+1];
   logic [EXT_W-1:0] num_ext, den_ext;

   assign num_ext = EXT_W'(in_num);
   assign den_ext = EXT_W'(in_den);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[QUO_W-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= num_ext;
         den_ff[0] <= den_ext;
         quo_ff[0] <= '0;
         sat_ff[0] <= (num_ext >= (den_ext << QUO_W));
         tag_ff[0] <= in_tag;
      end
   end

   for (genvar j = 1; j <= QUO_W; j++) begin : g_stage
      localparam int unsigned SH = QUO_W - j;
      logic [EXT_W-1:0] trial;
      logic             hit;
      assign trial = den_ff[j-1] << SH;
      assign hit   = (rem_ff[j-1] >= trial);
      always_ff @(posedge clock) begin
         if (en) begin
            quo_ff[j] <= hit ? (quo_ff[j-1] | (QUO_W'(1) << SH)) : quo_ff[j-1];
            sat_ff[j] <= sat_ff[j-1];
            tag_ff[j] <= tag_ff[j-1];
         end
      end
      if (j < QUO_W) begin : g_rem
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[j] <= hit ? (rem_ff[j-1] - trial) : rem_ff[j-1];
               den_ff[j] <= den_ff[j-1];
            end
         end
      end
   end

   assign out_valid = valid_ff[QUO_W];
   assign out_quo   = sat_ff[QUO_W] ? '1 : quo_ff[QUO_W];
   assign out_tag   = tag_ff[QUO_W];
endmodule

// ----- hdl/dsf_back.sv -----
// Back end: length, spring and damping terms, force scaling and saturation,
// with the response register. Depends on dsf_pkg, dsf_sqrt, dsf_div, dsf_rsp_if.
`timescale 1ns / 1ps
module dsf_back (
   input  logic               clock,
   input  logic               reset,
   input  dsf_pkg::cfg_type   cfg,
   input  logic               fifo_valid,
   input  dsf_pkg::entry_type fifo_entry,
   output logic               fifo_pop,
   dsf_rsp_if.source          rsp_if
);
   import dsf_pkg::*;

   logic en;
   logic rsp_valid_ff;
   logic signed [COORD_W-1:0] force_ff [3];
   logic signed [COORD_W-1:0] force_in [3];
   logic zero_ff;

   assign en       = !rsp_valid_ff || rsp_if.ready;
   assign fifo_pop = en;

   // Length of the separation.
   sq_tag_type        sq_tag_in, sq_tag_out;
   logic              sq_valid;
   logic [ROOT_W-1:0] sq_root;

   always_comb begin
      sq_tag_in.d      = fifo_entry.d;
      sq_tag_in.vd_neg = fifo_entry.vd_neg;
      sq_tag_in.vd_mag = fifo_entry.vd_mag;
      sq_tag_in.zero   = fifo_entry.zero;
   end

   dsf_sqrt #(.RAD_W(SUM_W), .ROOT_W(ROOT_W), .TAG_W($bits(sq_tag_type))) u_sqrt (
      .clock, .reset, .en,
      .in_valid(fifo_valid), .in_rad(fifo_entry.sum_sq), .in_tag(sq_tag_in),
      .out_valid(sq_valid), .out_root(sq_root), .out_tag(sq_tag_out)
   );

   logic signed [ROOT_W:0] diff;
   logic [ROOT_W:0]        diff_abs;
   logic                   p1_valid_ff;
   logic [NUM1_W-1:0]      p1_n1_ff;
   logic                   p1_diff_neg_ff;
   logic [SUM_W-1:0]       p1_vdmag_ff;
   divb_tag_type           p1_tag_ff;

   assign diff     = $signed({1'b0, sq_root}) - $signed({2'b00, cfg.rest_len});
   assign diff_abs = diff[ROOT_W] ? (ROOT_W + 1)'(-diff) : (ROOT_W + 1)'(diff);

   always_ff @(posedge clock) begin
      if (en) begin
         p1_n1_ff         <= NUM1_W'(cfg.stiffness) * NUM1_W'(diff_abs[ROOT_W-1:0]);
         p1_diff_neg_ff   <= diff[ROOT_W];
         p1_vdmag_ff      <= sq_tag_out.vd_mag;
         p1_tag_ff.d      <= sq_tag_out.d;
         p1_tag_ff.vd_neg <= sq_tag_out.vd_neg;
         p1_tag_ff.root   <= sq_root;
         p1_tag_ff.zero   <= sq_tag_out.zero;
      end
   end

   // Spring term and velocity over length.
   logic              da_valid, db_valid;
   logic [TERM_W-1:0] da_quo, db_quo;
   logic              da_tag;
   divb_tag_type      db_tag;

   dsf_div #(.NUM_W(NUM1_W), .DEN_W(K_W), .QUO_W(TERM_W), .TAG_W(1)) u_div_spring (
      .clock, .reset, .en,
      .in_valid(p1_valid_ff), .in_num(p1_n1_ff), .in_den(cfg.rest_len),
      .in_tag(p1_diff_neg_ff),
      .out_valid(da_valid), .out_quo(da_quo), .out_tag(da_tag)
   );

   dsf_div #(.NUM_W(SUM_W), .DEN_W(ROOT_W), .QUO_W(TERM_W),
      .TAG_W($bits(divb_tag_type))) u_div_vel (
      .clock, .reset, .en,
      .in_valid(p1_valid_ff), .in_num(p1_vdmag_ff), .in_den(p1_tag_ff.root),
      .in_tag(p1_tag_ff),
      .out_valid(db_valid), .out_quo(db_quo), .out_tag(db_tag)
   );

   logic              p2_valid_ff, p3_valid_ff;
   logic [PART_W-1:0] p2_plo_ff, p2_phi_ff;
   divc_tag_type      p2_tag_ff, p3_tag_ff;
   logic [NUM2_W-1:0] p3_n2_ff;
   logic [DEN2_W-1:0] damp_den;

   assign damp_den = DEN2_W'(cfg.rest_len) * DAMP_DIV;

   always_ff @(posedge clock) begin
      if (en) begin
         p2_plo_ff          <= PART_W'(cfg.stiffness) * PART_W'(db_quo[TERM_W/2-1:0]);
         p2_phi_ff          <= PART_W'(cfg.stiffness) * PART_W'(db_quo[TERM_W-1:TERM_W/2]);
         p2_tag_ff.m1       <= da_quo;
         p2_tag_ff.diff_neg <= da_tag;
         p2_tag_ff.vd_neg   <= db_tag.vd_neg;
         p2_tag_ff.d        <= db_tag.d;
         p2_tag_ff.root     <= db_tag.root;
         p2_tag_ff.zero     <= db_tag.zero;
         p3_n2_ff  <= NUM2_W'(p2_plo_ff) + (NUM2_W'(p2_phi_ff) << (TERM_W / 2));
         p3_tag_ff <= p2_tag_ff;
      end
   end

   // Damping term.
   logic              dc_valid;
   logic [TERM_W-1:0] dc_quo;
   divc_tag_type      dc_tag;

   dsf_div #(.NUM_W(NUM2_W), .DEN_W(DEN2_W), .QUO_W(TERM_W),
      .TAG_W($bits(divc_tag_type))) u_div_damp (
      .clock, .reset, .en,
      .in_valid(p3_valid_ff), .in_num(p3_n2_ff), .in_den(damp_den), .in_tag(p3_tag_ff),
      .out_valid(dc_valid), .out_quo(dc_quo), .out_tag(dc_tag)
   );

   logic signed [63:0]     m1_ext, m2_ext, s_val;
   logic                   p4_valid_ff, p5_valid_ff, p6_valid_ff;
   logic [SMAG_W-1:0]      p4_smag_ff;
   logic                   p4_sneg_ff;
   logic [2:0][DIFF_W-1:0] p4_d_ff;
   logic [ROOT_W-1:0]      p4_root_ff, p5_root_ff, p6_root_ff;
   logic                   p4_zero_ff, p5_zero_ff, p6_zero_ff;
   logic [DIFF_W-1:0]      dmag [3];
   logic [PA_W-1:0]        p5_pa_ff [3];
   logic [PB_W-1:0]        p5_pb_ff [3];
   logic [2:0]             p5_neg_ff, p6_neg_ff;
   logic [NUM3_W-1:0]      p6_n_ff [3];

   always_comb begin
      m1_ext = $signed({2'b00, dc_tag.m1});
      m2_ext = $signed({2'b00, dc_quo});
      s_val  = (dc_tag.diff_neg ? -m1_ext : m1_ext) + (dc_tag.vd_neg ? -m2_ext : m2_ext);
      for (int i = 0; i < 3; i++) begin
         dmag[i] = p4_d_ff[i][DIFF_W-1] ? DIFF_W'(-p4_d_ff[i]) : p4_d_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p4_sneg_ff <= s_val[63];
         p4_smag_ff <= s_val[63] ? SMAG_W'(-s_val) : SMAG_W'(s_val);
         p4_d_ff    <= dc_tag.d;
         p4_root_ff <= dc_tag.root;
         p4_zero_ff <= dc_tag.zero;
         for (int i = 0; i < 3; i++) begin
            p5_pa_ff[i]  <= PA_W'(p4_smag_ff[31:0]) * PA_W'(dmag[i]);
            p5_pb_ff[i]  <= PB_W'(p4_smag_ff[SMAG_W-1:32]) * PB_W'(dmag[i]);
            p5_neg_ff[i] <= p4_sneg_ff ^ p4_d_ff[i][DIFF_W-1];
            p6_n_ff[i]   <= NUM3_W'(p5_pa_ff[i]) + (NUM3_W'(p5_pb_ff[i]) << 32);
         end
         p5_root_ff <= p4_root_ff;
         p5_zero_ff <= p4_zero_ff;
         p6_neg_ff  <= p5_neg_ff;
         p6_root_ff <= p5_root_ff;
         p6_zero_ff <= p5_zero_ff;
      end
   end

   // Scaling by d over length, one divider per axis.
   logic                dx_valid, dy_valid, dz_valid;
   logic [FORCE_QW-1:0] dd_quo [3];
   logic [1:0]          dx_tag;
   logic                dy_tag, dz_tag;

   dsf_div #(.NUM_W(NUM3_W), .DEN_W(ROOT_W), .QUO_W(FORCE_QW), .TAG_W(2)) u_div_x (
      .clock, .reset, .en,
      .in_valid(p6_valid_ff), .in_num(p6_n_ff[0]), .in_den(p6_root_ff),
      .in_tag({p6_zero_ff, p6_neg_ff[0]}),
      .out_valid(dx_valid), .out_quo(dd_quo[0]), .out_tag(dx_tag)
   );

   dsf_div #(.NUM_W(NUM3_W), .DEN_W(ROOT_W), .QUO_W(FORCE_QW), .TAG_W(1)) u_div_y (
      .clock, .reset, .en,
      .in_valid(p6_valid_ff), .in_num(p6_n_ff[1]), .in_den(p6_root_ff),
      .in_tag(p6_neg_ff[1]),
      .out_valid(dy_valid), .out_quo(dd_quo[1]), .out_tag(dy_tag)
   );

   dsf_div #(.NUM_W(NUM3_W), .DEN_W(ROOT_W), .QUO_W(FORCE_QW), .TAG_W(1)) u_div_z (
      .clock, .reset, .en,
      .in_valid(p6_valid_ff), .in_num(p6_n_ff[2]), .in_den(p6_root_ff),
      .in_tag(p6_neg_ff[2]),
      .out_valid(dz_valid), .out_quo(dd_quo[2]), .out_tag(dz_tag)
   );

   logic [2:0] out_neg;

   always_comb begin
      out_neg = {dz_tag, dy_tag, dx_tag[0]};
      for (int i = 0; i < 3; i++) begin
         if (dx_tag[1]) begin
            force_in[i] = '0;
         end else if (out_neg[i]) begin
            force_in[i] = (dd_quo[i] > 32'h8000_0000) ? 32'sh8000_0000 : $signed(-dd_quo[i]);
         end else begin
            force_in[i] = (dd_quo[i] > 32'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(dd_quo[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         p3_valid_ff  <= 1'b0;
         p4_valid_ff  <= 1'b0;
         p5_valid_ff  <= 1'b0;
         p6_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         p1_valid_ff  <= sq_valid;
         p2_valid_ff  <= da_valid && db_valid;
         p3_valid_ff  <= p2_valid_ff;
         p4_valid_ff  <= dc_valid;
         p5_valid_ff  <= p4_valid_ff;
         p6_valid_ff  <= p5_valid_ff;
         rsp_valid_ff <= dx_valid && dy_valid && dz_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            force_ff[i] <= force_in[i];
         end
         zero_ff <= dx_tag[1];
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.force_x     = force_ff[0];
   assign rsp_if.force_y     = force_ff[1];
   assign rsp_if.force_z     = force_ff[2];
   assign rsp_if.zero_length = zero_ff;
endmodule

// ----- hdl/damped_spring_force.sv -----
// Damped spring force engine. Throughput: one request per cycle while the
// response channel is ready; every stage of the square root and of the
// bit-per-stage dividers is registered, so the longest chain is one stage.
// Reset is synchronous: it empties the pipeline and queue and sets stiffness
// and rest length to 1.0. There is no clearing pass.
// Depends on dsf_pkg, dsf_channels, dsf_front, dsf_fifo and dsf_back.
`timescale 1ns / 1ps
module damped_spring_force #(
   parameter int unsigned QUEUE_DEPTH = dsf_pkg::QUEUE_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   dsf_req_if.sink                         req_if,
   dsf_rsp_if.source                       rsp_if,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [dsf_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [dsf_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [dsf_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready
);
   import dsf_pkg::*;

   logic [CSR_DATA_W-1:0] stiffness_ff, rest_length_ff;
   logic                  csr_write;
   cfg_type               cfg;
   logic                  push_valid, push_ready, fifo_valid, fifo_pop;
   entry_type             push_entry, fifo_entry;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         stiffness_ff   <= STIFFNESS_RESET;
         rest_length_ff <= REST_LENGTH_RESET;
      end else if (csr_write) begin
         case (paddr[2])
            REG_STIFFNESS: begin
               stiffness_ff <= pwdata;
            end
            REG_REST_LENGTH: begin
               rest_length_ff <= pwdata;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_STIFFNESS: begin
            prdata = stiffness_ff;
         end
         REG_REST_LENGTH: begin
            prdata = rest_length_ff;
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   // A zero rest length is treated as the smallest nonzero one.
   assign cfg.stiffness = stiffness_ff;
   assign cfg.rest_len  = (rest_length_ff == '0) ? K_W'(1) : rest_length_ff;

   dsf_front u_front (
      .clock, .reset, .req_if,
      .push_valid, .push_ready, .push_entry
   );

   dsf_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
      .clock, .reset,
      .in_valid(push_valid), .in_ready(push_ready), .in_entry(push_entry),
      .out_valid(fifo_valid), .pop(fifo_pop), .out_entry(fifo_entry)
   );

   dsf_back u_back (
      .clock, .reset, .cfg,
      .fifo_valid, .fifo_entry, .fifo_pop, .rsp_if
   );
endmodule
